// ===== hw/rtl/mam_pkg.sv =====
// ----------------------------------------------------------------------------
// mam_pkg
// Shared types and constants for the medial atom normals unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mam_pkg;

  // data format
  localparam int unsigned DW      = 32;           // word width
  localparam int unsigned FB      = 16;           // fraction bits
  localparam int unsigned IC_W    = 10;           // interval count width
  localparam logic [IC_W-1:0] IC_RESET = IC_W'(1);
  localparam int unsigned Q_DEPTH = 2;            // front/back queue depth

  // radius root
  localparam int unsigned RAD_W   = DW + FB;      // radicand of the radius root
  localparam int unsigned R_W     = RAD_W / 2;    // radius width

  // radius derivative divide
  localparam int unsigned DIFF_W  = DW + 1;
  localparam int unsigned NUM1_W  = DIFF_W + IC_W + FB;
  localparam int unsigned DEN1_W  = R_W + 2;
  localparam int unsigned RT_W    = DW;
  localparam logic [RT_W-1:0] RT_CAP_POS = {1'b0, {(RT_W-1){1'b1}}};
  localparam logic [RT_W-1:0] RT_CAP_NEG = {1'b1, {(RT_W-1){1'b0}}};

  // normal terms
  localparam int unsigned L_W     = 2 * DW;       // squared tangent length
  localparam int unsigned SQ_W    = DW;           // root of the clamped radicand
  localparam int unsigned NUM2_W  = L_W + FB;
  localparam int unsigned TQ_W    = DW + 2;       // term quotient width
  localparam logic [TQ_W-1:0] TERM_CAP = {1'b1, {(TQ_W-1){1'b0}}};
  localparam int unsigned TERM_W  = TQ_W + 1;
  localparam int unsigned SUM_W   = TERM_W + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_RAD  = 2'd1,
    ST_ZERO_RAD = 2'd2,
    ST_ZERO_TAN = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] tan_x;
    logic signed [DW-1:0] tan_y;
    logic signed [DW-1:0] sqrad_prev;
    logic signed [DW-1:0] sqrad_here;
    logic signed [DW-1:0] sqrad_next;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic [DW-2:0]        radius_val;
    logic signed [DW-1:0] norm_a_x;
    logic signed [DW-1:0] norm_a_y;
    logic signed [DW-1:0] norm_b_x;
    logic signed [DW-1:0] norm_b_y;
    logic [1:0]           status;
  } out_word_t;

  // classified item, as queued between front and back
  typedef struct packed {
    logic signed [DW-1:0]     pos_x;
    logic signed [DW-1:0]     pos_y;
    logic signed [DW-1:0]     tan_x;
    logic signed [DW-1:0]     tan_y;
    logic [DW-1:0]            sqrad;
    logic signed [DIFF_W-1:0] diff;
    status_e                  status;
  } qent_t;

endpackage

`default_nettype wire

// ===== hw/rtl/medial_atom_normals_unit.sv =====
// ----------------------------------------------------------------------------
// medial_atom_normals_unit
// Boundary normals of one medial curve sample, signed Q16.16.
//
//   channel  | ports                          | direction | handshake
//   ---------+--------------------------------+-----------+----------------
//   sample   | start, busy, in_data_i         | in        | start & !busy
//   result   | result_valid_o, result_o       | out       | strobe, 1 cycle
//   config   | cfg_we_i, cfg_wdata_i          | in        | write enable
//
// One sample is taken per cycle. The result path runs through the queue
// stage, the two root pipelines (24 and 32 stages) and the two divider
// chains (33 and 35 stages). Reset clears the valid pipeline and the queue
// and sets the interval count to 1. The result side cannot stall and the
// back end pops every queued word at once, so busy stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module medial_atom_normals_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire mam_pkg::in_word_t         in_data_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [mam_pkg::IC_W-1:0]  cfg_wdata_i,
  output logic                           result_valid_o,
  output mam_pkg::out_word_t             result_o
);

  logic [mam_pkg::IC_W-1:0] ic_q;
  logic                     push, full, q_valid, take;
  mam_pkg::qent_t           push_ent, q_ent;

  // hold the interval count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= mam_pkg::IC_RESET;
    end else if (cfg_we_i) begin
      ic_q <= cfg_wdata_i;
    end
  end

  assign busy = full;

  mam_front u_front (
    .start_i   (start),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_ent)
  );

  mam_queue #(
    .DEPTH (mam_pkg::Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ent),
    .pop_i   (take),
    .valid_o (q_valid),
    .data_o  (q_ent),
    .full_o  (full)
  );

  mam_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .entry_i        (q_ent),
    .ic_i           (ic_q),
    .take_o         (take),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mam_front.sv =====
// ----------------------------------------------------------------------------
// mam_front
// Accepts a sample, classifies it and forms the squared-radius difference.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_front (
  input  wire logic              start_i,
  input  wire mam_pkg::in_word_t in_data_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output mam_pkg::qent_t         entry_o
);

  // take the word whenever the queue has room
  assign push_o = start_i && !full_i;

  // classify: negative squared radius, zero radius, zero tangent
  always_comb begin
    entry_o.pos_x = in_data_i.pos_x;
    entry_o.pos_y = in_data_i.pos_y;
    entry_o.tan_x = in_data_i.tan_x;
    entry_o.tan_y = in_data_i.tan_y;
    entry_o.sqrad = mam_pkg::DW'(in_data_i.sqrad_here);
    entry_o.diff  = mam_pkg::DIFF_W'(in_data_i.sqrad_next)
                  - mam_pkg::DIFF_W'(in_data_i.sqrad_prev);
    if (in_data_i.sqrad_here < 0) begin
      entry_o.status = mam_pkg::ST_NEG_RAD;
    end else if (in_data_i.sqrad_here == 0) begin
      entry_o.status = mam_pkg::ST_ZERO_RAD;
    end else if (in_data_i.tan_x == 0 && in_data_i.tan_y == 0) begin
      entry_o.status = mam_pkg::ST_ZERO_TAN;
    end else begin
      entry_o.status = mam_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mam_queue.sv =====
// ----------------------------------------------------------------------------
// mam_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mam_pkg::qent_t data_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output mam_pkg::qent_t      data_o,
  output logic                full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mam_pkg::qent_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (PTR_W+1)'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mam_sqrt.sv =====
// ----------------------------------------------------------------------------
// mam_sqrt
// Pipelined floor square root, one root bit per stage, with a side tag.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_sqrt #(
  parameter int unsigned RAD_W = 48,
  parameter int unsigned TAG_W = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [RAD_W-1:0]   rad_i,
  input  wire logic [TAG_W-1:0]   tag_i,
  output logic                    valid_o,
  output logic [RAD_W/2-1:0]      root_o,
  output logic [TAG_W-1:0]        tag_o
);

  localparam int unsigned H  = RAD_W / 2;
  localparam int unsigned RW = H + 2;

  logic             vld_q  [H];
  logic [RW-1:0]    rem_q  [H];
  logic [H-1:0]     root_q [H];
  logic [RAD_W-1:0] rad_q  [H];
  logic [TAG_W-1:0] tag_q  [H];

  for (genvar k = 0; k < H; k++) begin : g_step
    logic             v_in;
    logic [RW-1:0]    rem_in, rem_sh, trial, rem_nx;
    logic [H-1:0]     root_in;
    logic [RAD_W-1:0] rad_in;
    logic [TAG_W-1:0] tag_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_nx;
      root_q[k] <= {root_in[H-2:0], ge};
      rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      tag_q[k]  <= tag_in;
    end
  end

  assign valid_o = vld_q[H-1];
  assign root_o  = root_q[H-1];
  assign tag_o   = tag_q[H-1];

endmodule

`default_nettype wire

// ===== hw/rtl/mam_div.sv =====
// ----------------------------------------------------------------------------
// mam_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// that does not fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_div #(
  parameter int unsigned NUM_W = 59,
  parameter int unsigned DEN_W = 26,
  parameter int unsigned Q_W   = 32,
  parameter int unsigned TAG_W = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  input  wire logic [TAG_W-1:0]   tag_i,
  output logic                    valid_o,
  output logic [Q_W-1:0]          quot_o,
  output logic                    ovf_o,
  output logic [TAG_W-1:0]        tag_o
);

  localparam int unsigned HW = NUM_W - Q_W;
  localparam int unsigned CW = (HW > DEN_W) ? HW : DEN_W;

  logic             vld_q [Q_W+1];
  logic [DEN_W-1:0] rem_q [Q_W+1];
  logic [Q_W-1:0]   low_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic             ovf_q [Q_W+1];
  logic [TAG_W-1:0] tag_q [Q_W+1];

  logic [CW-1:0] hi_x, den_x;

  assign hi_x  = CW'(num_i[NUM_W-1:Q_W]);
  assign den_x = CW'(den_i);

  // entry stage: split off the high part and check for overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= DEN_W'(hi_x);
    low_q[0] <= num_i[Q_W-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    ovf_q[0] <= (hi_x >= den_x);
    tag_q[0] <= tag_i;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] rem_sh, den_ext;
    logic           ge;

    // shift in one numerator bit and subtract where it fits
    assign rem_sh  = {rem_q[k], low_q[k][Q_W-1]};
    assign den_ext = {1'b0, den_q[k]};
    assign ge      = (rem_sh >= den_ext);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? DEN_W'(rem_sh - den_ext) : rem_sh[DEN_W-1:0];
      low_q[k+1] <= {low_q[k][Q_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][Q_W-2:0], ge};
      den_q[k+1] <= den_q[k];
      ovf_q[k+1] <= ovf_q[k];
      tag_q[k+1] <= tag_q[k];
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quot_o  = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

`default_nettype wire

// ===== hw/rtl/mam_back.sv =====
// ----------------------------------------------------------------------------
// mam_back
// Execution pipeline: radius root, radius derivative, tangent length,
// clamped root, four normal terms, sums and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire mam_pkg::qent_t            entry_i,
  input  wire logic [mam_pkg::IC_W-1:0]  ic_i,
  output logic                           take_o,
  output logic                           result_valid_o,
  output mam_pkg::out_word_t             result_o
);

  typedef struct packed {
    mam_pkg::qent_t            ent;
    logic [mam_pkg::R_W-1:0]   r;
    logic                      neg;
  } item_tag_t;

  typedef struct packed {
    mam_pkg::qent_t            ent;
    logic [mam_pkg::R_W-1:0]   r;
    logic [mam_pkg::RT_W-1:0]  mrt;
    logic                      rt_neg;
    logic [mam_pkg::DW-1:0]    mx;
    logic [mam_pkg::DW-1:0]    my;
    logic [mam_pkg::L_W-1:0]   l;
  } sq_tag_t;

  typedef logic signed [mam_pkg::TERM_W-1:0] term_t;

  // saturate a sum to the signed word range
  function automatic logic signed [mam_pkg::DW-1:0] sat_out(
    input logic signed [mam_pkg::SUM_W-1:0] v
  );
    logic [mam_pkg::SUM_W-mam_pkg::DW:0] top;
    top = v[mam_pkg::SUM_W-1:mam_pkg::DW-1];
    if (&top || ~|top) begin
      return v[mam_pkg::DW-1:0];
    end else if (v[mam_pkg::SUM_W-1]) begin
      return {1'b1, {(mam_pkg::DW-1){1'b0}}};
    end else begin
      return {1'b0, {(mam_pkg::DW-1){1'b1}}};
    end
  endfunction

  // never stalls: take every queued word
  assign take_o = valid_i;

  // ---- radius root ----
  logic                       s1_v;
  logic [mam_pkg::R_W-1:0]    s1_r;
  logic [$bits(mam_pkg::qent_t)-1:0] s1_tag;
  mam_pkg::qent_t             s1_ent;

  mam_sqrt #(
    .RAD_W (mam_pkg::RAD_W),
    .TAG_W ($bits(mam_pkg::qent_t))
  ) u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .rad_i   ({entry_i.sqrad, {mam_pkg::FB{1'b0}}}),
    .tag_i   (entry_i),
    .valid_o (s1_v),
    .root_o  (s1_r),
    .tag_o   (s1_tag)
  );

  assign s1_ent = s1_tag;

  // ---- scale the difference by the interval count ----
  logic                          b_v_q;
  logic [mam_pkg::NUM1_W-1:0]    b_num_q;
  logic [mam_pkg::DEN1_W-1:0]    b_den_q;
  item_tag_t                     b_tag_q;
  logic [mam_pkg::DIFF_W-1:0]    dm;
  logic [mam_pkg::DIFF_W+mam_pkg::IC_W-1:0] dm_ic;

  assign dm    = s1_ent.diff[mam_pkg::DIFF_W-1]
               ? mam_pkg::DIFF_W'(-s1_ent.diff) : mam_pkg::DIFF_W'(s1_ent.diff);
  assign dm_ic = (mam_pkg::DIFF_W+mam_pkg::IC_W)'(dm)
               * (mam_pkg::DIFF_W+mam_pkg::IC_W)'(ic_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else begin
      b_v_q <= s1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    b_num_q     <= {dm_ic, {mam_pkg::FB{1'b0}}};
    b_den_q     <= {s1_r, 2'b00};
    b_tag_q.ent <= s1_ent;
    b_tag_q.r   <= s1_r;
    b_tag_q.neg <= s1_ent.diff[mam_pkg::DIFF_W-1];
  end

  // ---- radius derivative divide ----
  logic                       d1_v, d1_ovf;
  logic [mam_pkg::RT_W-1:0]   d1_q;
  logic [$bits(item_tag_t)-1:0] d1_tag;
  item_tag_t                  d1_t;

  mam_div #(
    .NUM_W (mam_pkg::NUM1_W),
    .DEN_W (mam_pkg::DEN1_W),
    .Q_W   (mam_pkg::RT_W),
    .TAG_W ($bits(item_tag_t))
  ) u_div_rt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_v_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .tag_i   (b_tag_q),
    .valid_o (d1_v),
    .quot_o  (d1_q),
    .ovf_o   (d1_ovf),
    .tag_o   (d1_tag)
  );

  assign d1_t = d1_tag;

  // ---- cap the derivative, take tangent magnitudes ----
  logic                     c_v_q;
  sq_tag_t                  c_q;
  logic [mam_pkg::RT_W-1:0] rt_cap, mrt;

  assign rt_cap = d1_t.neg ? mam_pkg::RT_CAP_NEG : mam_pkg::RT_CAP_POS;
  assign mrt    = (d1_ovf || d1_q > rt_cap) ? rt_cap : d1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q.ent    <= d1_t.ent;
    c_q.r      <= d1_t.r;
    c_q.mrt    <= mrt;
    c_q.rt_neg <= d1_t.neg && (mrt != '0);
    c_q.mx     <= d1_t.ent.tan_x[mam_pkg::DW-1]
                ? (mam_pkg::DW'(0) - mam_pkg::DW'(d1_t.ent.tan_x))
                : mam_pkg::DW'(d1_t.ent.tan_x);
    c_q.my     <= d1_t.ent.tan_y[mam_pkg::DW-1]
                ? (mam_pkg::DW'(0) - mam_pkg::DW'(d1_t.ent.tan_y))
                : mam_pkg::DW'(d1_t.ent.tan_y);
    c_q.l      <= '0;
  end

  // ---- squares ----
  logic                    e_v_q;
  sq_tag_t                 e_q;
  logic [mam_pkg::L_W-1:0] e_lx_q, e_ly_q, e_rt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
    end else begin
      e_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= c_q;
    e_lx_q  <= mam_pkg::L_W'(c_q.mx) * mam_pkg::L_W'(c_q.mx);
    e_ly_q  <= mam_pkg::L_W'(c_q.my) * mam_pkg::L_W'(c_q.my);
    e_rt2_q <= mam_pkg::L_W'(c_q.mrt) * mam_pkg::L_W'(c_q.mrt);
  end

  // ---- tangent length ----
  logic                    f_v_q;
  sq_tag_t                 f_q;
  logic [mam_pkg::L_W-1:0] f_rt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else begin
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q.ent    <= e_q.ent;
    f_q.r      <= e_q.r;
    f_q.mrt    <= e_q.mrt;
    f_q.rt_neg <= e_q.rt_neg;
    f_q.mx     <= e_q.mx;
    f_q.my     <= e_q.my;
    f_q.l      <= e_lx_q + e_ly_q;
    f_rt2_q    <= e_rt2_q;
  end

  // ---- clamped radicand ----
  logic                    g_v_q;
  sq_tag_t                 g_q;
  logic [mam_pkg::L_W-1:0] g_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q     <= f_q;
    g_rad_q <= (f_q.l > f_rt2_q) ? (f_q.l - f_rt2_q) : '0;
  end

  // ---- root of the clamped radicand ----
  logic                     s2_v;
  logic [mam_pkg::SQ_W-1:0] s2_sq;
  logic [$bits(sq_tag_t)-1:0] s2_tag;
  sq_tag_t                  s2_t;

  mam_sqrt #(
    .RAD_W (mam_pkg::L_W),
    .TAG_W ($bits(sq_tag_t))
  ) u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_v_q),
    .rad_i   (g_rad_q),
    .tag_i   (g_q),
    .valid_o (s2_v),
    .root_o  (s2_sq),
    .tag_o   (s2_tag)
  );

  assign s2_t = s2_tag;

  // ---- term products ----
  logic                    p_v_q;
  item_tag_t               p_tag_q;
  logic [mam_pkg::L_W-1:0] p_l_q;
  logic [mam_pkg::L_W-1:0] p_prod_q [4];
  logic                    p_neg_q  [4];
  logic                    tx_neg, ty_neg;

  assign tx_neg = s2_t.ent.tan_x[mam_pkg::DW-1];
  assign ty_neg = s2_t.ent.tan_y[mam_pkg::DW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= s2_v;
    end
  end

  // lanes: 0 a*tx, 1 a*ty, 2 b*ty, 3 b*tx
  always_ff @(posedge clk_i) begin
    p_tag_q.ent <= s2_t.ent;
    p_tag_q.r   <= s2_t.r;
    p_tag_q.neg <= (s2_t.rt_neg == tx_neg);
    p_l_q       <= s2_t.l;
    p_prod_q[0] <= mam_pkg::L_W'(s2_t.mrt) * mam_pkg::L_W'(s2_t.mx);
    p_prod_q[1] <= mam_pkg::L_W'(s2_t.mrt) * mam_pkg::L_W'(s2_t.my);
    p_prod_q[2] <= mam_pkg::L_W'(s2_sq) * mam_pkg::L_W'(s2_t.my);
    p_prod_q[3] <= mam_pkg::L_W'(s2_sq) * mam_pkg::L_W'(s2_t.mx);
    p_neg_q[0]  <= (s2_t.rt_neg == tx_neg);
    p_neg_q[1]  <= (s2_t.rt_neg == ty_neg);
    p_neg_q[2]  <= ty_neg;
    p_neg_q[3]  <= tx_neg;
  end

  // ---- four term divides ----
  logic                     t_v    [4];
  logic                     t_ovf  [4];
  logic [mam_pkg::TQ_W-1:0] t_quot [4];
  logic                     t_neg  [4];
  logic [$bits(item_tag_t)-1:0] lead_tag;
  item_tag_t                lead_t;

  mam_div #(
    .NUM_W (mam_pkg::NUM2_W),
    .DEN_W (mam_pkg::L_W),
    .Q_W   (mam_pkg::TQ_W),
    .TAG_W ($bits(item_tag_t))
  ) u_div_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_v_q),
    .num_i   ({p_prod_q[0], {mam_pkg::FB{1'b0}}}),
    .den_i   (p_l_q),
    .tag_i   (p_tag_q),
    .valid_o (t_v[0]),
    .quot_o  (t_quot[0]),
    .ovf_o   (t_ovf[0]),
    .tag_o   (lead_tag)
  );

  assign lead_t   = lead_tag;
  assign t_neg[0] = lead_t.neg;

  for (genvar j = 1; j < 4; j++) begin : g_term
    mam_div #(
      .NUM_W (mam_pkg::NUM2_W),
      .DEN_W (mam_pkg::L_W),
      .Q_W   (mam_pkg::TQ_W),
      .TAG_W (1)
    ) u_div_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p_v_q),
      .num_i   ({p_prod_q[j], {mam_pkg::FB{1'b0}}}),
      .den_i   (p_l_q),
      .tag_i   (p_neg_q[j]),
      .valid_o (t_v[j]),
      .quot_o  (t_quot[j]),
      .ovf_o   (t_ovf[j]),
      .tag_o   (t_neg[j])
    );
  end

  // ---- cap and sign the terms ----
  logic           h_v_q;
  item_tag_t      h_tag_q;
  term_t          h_term_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else begin
      h_v_q <= t_v[0] && t_v[1] && t_v[2] && t_v[3];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_cap
    logic [mam_pkg::TQ_W-1:0] mag;
    assign mag = (t_ovf[j] || t_quot[j] > mam_pkg::TERM_CAP) ? mam_pkg::TERM_CAP
                                                            : t_quot[j];
    always_ff @(posedge clk_i) begin
      h_term_q[j] <= t_neg[j] ? -term_t'({1'b0, mag}) : term_t'({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i) begin
    h_tag_q <= lead_t;
  end

  // ---- sums, saturation and status masking ----
  logic                          o_v_q;
  mam_pkg::out_word_t            o_q;
  logic signed [mam_pkg::SUM_W-1:0] n1x, n1y, n2x, n2y;
  logic                          ok;

  assign n1x = mam_pkg::SUM_W'(h_term_q[0]) - mam_pkg::SUM_W'(h_term_q[2]);
  assign n2x = mam_pkg::SUM_W'(h_term_q[0]) + mam_pkg::SUM_W'(h_term_q[2]);
  assign n1y = mam_pkg::SUM_W'(h_term_q[1]) + mam_pkg::SUM_W'(h_term_q[3]);
  assign n2y = mam_pkg::SUM_W'(h_term_q[1]) - mam_pkg::SUM_W'(h_term_q[3]);
  assign ok  = (h_tag_q.ent.status == mam_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q.out_x      <= h_tag_q.ent.pos_x;
    o_q.out_y      <= h_tag_q.ent.pos_y;
    o_q.radius_val <= (h_tag_q.ent.status == mam_pkg::ST_NEG_RAD) ? '0
                    : (mam_pkg::DW-1)'(h_tag_q.r);
    o_q.norm_a_x   <= ok ? sat_out(n1x) : '0;
    o_q.norm_a_y   <= ok ? sat_out(n1y) : '0;
    o_q.norm_b_x   <= ok ? sat_out(n2x) : '0;
    o_q.norm_b_y   <= ok ? sat_out(n2y) : '0;
    o_q.status     <= h_tag_q.ent.status;
  end

  assign result_valid_o = o_v_q;
  assign result_o       = o_q;

endmodule

`default_nettype wire

// ===== tb/tb_medial_atom_normals_unit.sv =====
// ----------------------------------------------------------------------------
// tb_medial_atom_normals_unit
// Self-checking bench for the medial atom normals unit: a directed table of
// samples followed by random curve samples, each result compared field by
// field with a bit-exact fixed-point normal predictor, under random start gaps
// and several interval count settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_medial_atom_normals_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned   N_RANDOM    = 1800;
  localparam int unsigned   DRAIN_WAIT  = 200;
  localparam longint        CYCLE_LIMIT = 400000;
  localparam logic [63:0]   TCAP        = 64'd1 << 33;
  localparam longint        SAT_MAX     = 64'sd2147483647;
  localparam longint        SAT_MIN     = -64'sd2147483648;

  // one directed sample, with the result typed in where it is plain
  typedef struct {
    mam_pkg::in_word_t  smp;
    bit                 known;
    mam_pkg::out_word_t res;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  mam_pkg::in_word_t  in_data_i;
  logic      cfg_we_i;
  logic [mam_pkg::IC_W-1:0] cfg_wdata_i;
  logic      result_valid_o;
  mam_pkg::out_word_t result_o;

  logic [mam_pkg::IC_W-1:0] icount;
  mam_pkg::out_word_t       normals_q[$];
  int unsigned     n_fail;
  int unsigned     n_checked;
  int unsigned     n_stat[4];
  longint          cycles;

  medial_atom_normals_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_data_i      (in_data_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // floor square root of a 64-bit value
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // min(floor(mag * 2^FB / den), cap)
  function automatic logic [63:0] frac_quot(logic [63:0] mag, logic [63:0] den,
                                            logic [63:0] cap);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, mag} << mam_pkg::FB;
    q = num / {64'd0, den};
    return (q > {64'd0, cap}) ? cap : q[63:0];
  endfunction

  function automatic longint signed_term(logic [63:0] ma, logic [63:0] mb, bit neg,
                                         logic [63:0] den);
    logic [63:0] q;
    q = frac_quot(ma * mb, den, TCAP);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [mam_pkg::DW-1:0] clamp_word(longint v);
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    return v[mam_pkg::DW-1:0];
  endfunction

  function automatic logic [63:0] mag_of(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // expected result of one sample at the current interval count
  function automatic mam_pkg::out_word_t predict_normals(mam_pkg::in_word_t s);
    mam_pkg::out_word_t o;
    longint      tx, ty, sp, sh, sn, d, rt, ax, ay, bx, by;
    logic [63:0] r, dm, q, mrt, mx, my, l, rt2, sq;
    mam_pkg::status_e st;
    tx = s.tan_x; ty = s.tan_y;
    sp = s.sqrad_prev; sh = s.sqrad_here; sn = s.sqrad_next;
    o = '0;
    o.out_x = s.pos_x;
    o.out_y = s.pos_y;
    r = 0;
    st = mam_pkg::ST_OK;
    if (sh < 0) begin
      st = mam_pkg::ST_NEG_RAD;
    end else begin
      r = root_floor(64'(sh) << mam_pkg::FB);
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      if (r == 0) st = mam_pkg::ST_ZERO_RAD;
      else if (tx == 0 && ty == 0) st = mam_pkg::ST_ZERO_TAN;
    end
    if (st == mam_pkg::ST_OK) begin
      d = sn - sp;
      dm = mag_of(d);
      q = frac_quot(dm * 64'(icount), 64'd4 * r,
                    d < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF);
      rt = d < 0 ? -longint'(q) : longint'(q);
      mrt = mag_of(rt); mx = mag_of(tx); my = mag_of(ty);
      l = mx * mx + my * my;
      rt2 = mrt * mrt;
      sq = root_floor(l > rt2 ? l - rt2 : 64'd0);
      ax = signed_term(mrt, mx, !((rt < 0) != (tx < 0)), l);
      ay = signed_term(mrt, my, !((rt < 0) != (ty < 0)), l);
      by = signed_term(sq, my, ty < 0, l);
      bx = signed_term(sq, mx, tx < 0, l);
      o.norm_a_x = clamp_word(ax - by);
      o.norm_b_x = clamp_word(ax + by);
      o.norm_a_y = clamp_word(ay + bx);
      o.norm_b_y = clamp_word(ay - bx);
    end
    o.radius_val = r[mam_pkg::DW-2:0];
    o.status = st;
    return o;
  endfunction

  // random sample: mostly well-formed radii, sometimes raw noise
  function automatic mam_pkg::in_word_t rand_sample();
    mam_pkg::in_word_t s;
    int unsigned k;
    s.pos_x = $urandom; s.pos_y = $urandom;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      s.tan_x = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      s.tan_y = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
      s.sqrad_here = $urandom_range(1, 32'h00FF_FFFF);
      s.sqrad_prev = s.sqrad_here + ($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
      s.sqrad_next = s.sqrad_here + ($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
    end else begin
      s.tan_x = $urandom; s.tan_y = $urandom;
      s.sqrad_prev = $urandom; s.sqrad_here = $urandom; s.sqrad_next = $urandom;
      if (k == 9) s.tan_x = 0;
      if (k == 9 && $urandom_range(0, 1)) s.tan_y = 0;
    end
    return s;
  endfunction

  function automatic mam_pkg::in_word_t mk(logic [31:0] px, logic [31:0] py,
                                           logic [31:0] tx, logic [31:0] ty,
                                           logic [31:0] sp, logic [31:0] sh,
                                           logic [31:0] sn);
    mam_pkg::in_word_t s;
    s.pos_x = px; s.pos_y = py; s.tan_x = tx; s.tan_y = ty;
    s.sqrad_prev = sp; s.sqrad_here = sh; s.sqrad_next = sn;
    return s;
  endfunction

  function automatic mam_pkg::out_word_t plain_res(mam_pkg::in_word_t s, logic [30:0] r,
                                                   mam_pkg::status_e st);
    mam_pkg::out_word_t o;
    o = '0;
    o.out_x = s.pos_x; o.out_y = s.pos_y; o.radius_val = r; o.status = st;
    return o;
  endfunction

  // random idle stretch before the next word, mostly short
  task automatic idle_gap();
    int unsigned n;
    n = $urandom_range(0, 9);
    if (n < 5) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // present one word and wait for the edge that takes it
  task automatic send_sample(mam_pkg::in_word_t s, bit known, mam_pkg::out_word_t res);
    start <= 1'b1;
    in_data_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    normals_q.push_back(known ? res : predict_normals(s));
  endtask

  // drop start and wait until every expected word is back
  task automatic drain_all();
    start <= 1'b0;
    while (normals_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_icount(logic [mam_pkg::IC_W-1:0] v);
    drain_all();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    icount = v;
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    mam_pkg::out_word_t e;
    if (rst_ni && result_valid_o) begin
      if (normals_q.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        e = normals_q.pop_front();
        n_checked++;
        n_stat[result_o.status]++;
        if (result_o.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, result_o.out_x); n_fail++;
        end
        if (result_o.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, result_o.out_y); n_fail++;
        end
        if (result_o.radius_val !== e.radius_val) begin
          $error("radius_val exp %h got %h", e.radius_val, result_o.radius_val); n_fail++;
        end
        if (result_o.norm_a_x !== e.norm_a_x) begin
          $error("norm_a_x exp %h got %h", e.norm_a_x, result_o.norm_a_x); n_fail++;
        end
        if (result_o.norm_a_y !== e.norm_a_y) begin
          $error("norm_a_y exp %h got %h", e.norm_a_y, result_o.norm_a_y); n_fail++;
        end
        if (result_o.norm_b_x !== e.norm_b_x) begin
          $error("norm_b_x exp %h got %h", e.norm_b_x, result_o.norm_b_x); n_fail++;
        end
        if (result_o.norm_b_y !== e.norm_b_y) begin
          $error("norm_b_y exp %h got %h", e.norm_b_y, result_o.norm_b_y); n_fail++;
        end
        if (result_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result_o.status); n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    dir_row_t    row;
    mam_pkg::in_word_t s;
    logic [mam_pkg::IC_W-1:0] settings[5];
    int unsigned ph;
    int unsigned i;
    cycles = 0; n_fail = 0; n_checked = 0;
    foreach (n_stat[j]) n_stat[j] = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    icount = mam_pkg::IC_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed samples: status codes, field extremes, radicand clamp
    s = mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF, 0);
    rows.push_back('{s, 1, plain_res(s, 0, mam_pkg::ST_NEG_RAD)});
    s = mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0, 0, 32'h8000_0000, 0);
    rows.push_back('{s, 1, plain_res(s, 0, mam_pkg::ST_NEG_RAD)});
    s = mk(32'hFFFF_FFFF, 0, 32'h0001_0000, 32'h0001_0000, 5, 0, 7);
    rows.push_back('{s, 1, plain_res(s, 0, mam_pkg::ST_ZERO_RAD)});
    s = mk(1, 2, 0, 0, 0, 32'h0001_0000, 0);
    rows.push_back('{s, 1, plain_res(s, 31'h0001_0000, mam_pkg::ST_ZERO_TAN)});
    s = mk(3, 4, 0, 0, 0, 32'h0004_0000, 32'h7FFF_FFFF);
    rows.push_back('{s, 1, plain_res(s, 31'h0002_0000, mam_pkg::ST_ZERO_TAN)});
    s = mk(0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
    rows.push_back('{s, 1, plain_res(s, 31'h00B5_04F3, mam_pkg::ST_ZERO_TAN)});
    rows.push_back('{mk(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0), 0, '0});
    rows.push_back('{mk(0, 0, 0, 32'hFFFF_0000, 0, 32'h0001_0000, 0), 0, '0});
    rows.push_back('{mk(0, 0, 32'h0001_0000, 0, 32'h8000_0000, 1, 32'h7FFF_FFFF), 0, '0});
    rows.push_back('{mk(0, 0, 32'h0001_0000, 0, 32'h7FFF_FFFF, 1, 32'h8000_0000), 0, '0});
    rows.push_back('{mk(0, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0), 0, '0});
    rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000), 0, '0});
    rows.push_back('{mk(0, 0, 1, 1, 0, 32'h0001_0000, 32'h0010_0000), 0, '0});
    rows.push_back('{mk(0, 0, 1, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(5, 6, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 32'h0002_0000,
                        32'h0001_0000), 0, '0});
    rows.push_back('{mk(0, 0, 32'h0000_0100, 32'hFFFF_FF00, 32'h0100_0000, 32'h0000_0100,
                        0), 0, '0});
    foreach (rows[j]) begin
      row = rows[j];
      send_sample(row.smp, row.known, row.res);
      idle_gap();
    end

    // random phases across interval count settings, extremes included
    settings = '{10'd1023, 10'd0, 10'd1, 10'd7, 10'd512};
    for (ph = 0; ph < 5; ph++) begin
      if (ph == 4) set_icount(10'($urandom_range(2, 1022)));
      else set_icount(settings[ph]);
      if (ph == 3) begin
        set_icount(settings[4]);
        set_icount(10'h155);
        set_icount(10'h2AA);
      end
      for (i = 0; i < N_RANDOM / 5; i++) begin
        send_sample(rand_sample(), 0, '0);
        if (i % 64 == 0) idle_gap();
        else if ($urandom_range(0, 3) == 0) idle_gap();
        // let the pipeline empty once per phase
        if (i == N_RANDOM / 10) drain_all();
      end
    end

    drain_all();
    $display("checked %0d results: ok %0d, neg radius %0d, zero radius %0d, zero tangent %0d",
             n_checked, n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
    $display("directed extremes plus random samples over interval counts 0 to 1023");
    if (n_fail == 0 && normals_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/mam_pkg.sv
hw/rtl/mam_front.sv
hw/rtl/mam_queue.sv
hw/rtl/mam_sqrt.sv
hw/rtl/mam_div.sv
hw/rtl/mam_back.sv
hw/rtl/medial_atom_normals_unit.sv
tb/tb_medial_atom_normals_unit.sv
